@@ hdl/swm_pkg.sv @@
package swm_pkg;

    // Width and reset value of the window length register
    localparam int          CFG_BITS = 7;
    localparam logic [6:0]  WS_RESET = 7'd3;

    // Per-cell flags seen by the left neighbor
    typedef struct packed {
        logic evb;  // entry sits past the slot being evicted
        logic gt;   // entry is valid and greater than the incoming sample
    } t_cell_flags;

    // Broadcast control for the whole row of cells
    typedef struct packed {
        logic ins;    // a sample transaction is accepted this cycle
        logic ev;     // the oldest entry leaves in this step
        logic purge;  // eviction-only cycle, no sample enters
    } t_cell_ctrl;

endpackage

@@ hdl/sliding_window_median_core.sv @@
// Channel   Signals                                   Direction  Transaction when
// input     i_sample, i_start_req                     in         i_in_valid & !o_in_stall
// output    o_median_doubled                          out        o_out_valid & !i_out_stall
// config    i_cfg_wdata (window size)                 in         i_cfg_we
//
// One sample per cycle while the input is not stalled: the row of cells removes the oldest
// entry and inserts the new one in the same clock; a completed result is marked pending and
// is loaded into the output register once that register is free.
// Shrinking the window below the current fill runs eviction cycles, each removing one surplus
// entry, with the input stalled, before the next sample is taken.
// Synchronous active-low reset empties the window and sets the window size to 3.
// Apart from eviction cycles, the input stalls only when a result is pending and the
// output register is held.
module sliding_window_median_core
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_BITS-1:0]           i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_start_req,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS:0]   o_median_doubled
);

    localparam int N  = WINDOW_MAX;
    localparam int W  = SAMPLE_BITS;
    localparam int KW = $clog2(WINDOW_MAX + 1);
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic [CFG_BITS-1:0] r_ws;
    logic [KW-1:0]       r_fill, n_fill;
    logic                r_pend, n_pend;
    logic                r_out_valid, n_out_valid;
    logic signed [W:0]   r_med, n_med;

    logic [31:0]   k32;
    logic [KW-1:0] k, mid_lo, mid_hi;
    logic [KW-1:0] fill_base, fill_m1, fill_post;
    logic [AW-1:0] ev_age;
    logic          purge, ev_need, acc, load, done;
    t_cell_ctrl    ctrl;
    logic [W-1:0]  ev_val, lo_val, hi_val;

    // Chain links; index N on the right and 0 on the left are the row ends
    logic [W-1:0]  val_a      [N+1];
    logic [AW-1:0] age_a      [N+1];
    t_cell_flags   flags_a    [N+1];
    logic [W-1:0]  post_val_a [N+1];
    logic [AW-1:0] post_age_a [N+1];
    logic          post_gt_a  [N+1];
    logic [W-1:0]  ev_tap     [N];
    logic [W-1:0]  lo_tap     [N];
    logic [W-1:0]  hi_tap     [N];

    // Effective window length: zero reads as one, saturate at the cell count
    always_comb begin
        if (r_ws == '0) begin
            k32 = 32'd1;
        end else if (32'(r_ws) > 32'(WINDOW_MAX)) begin
            k32 = 32'(WINDOW_MAX);
        end else begin
            k32 = 32'(r_ws);
        end
    end
    assign k      = k32[KW-1:0];
    assign mid_lo = (k - KW'(1)) >> 1;
    assign mid_hi = k >> 1;

    // Step control
    assign purge      = (r_fill > k) && !r_pend;
    assign o_in_stall = purge || (r_pend && r_out_valid && i_out_stall);
    assign acc        = i_in_valid && !o_in_stall;
    assign fill_base  = (!purge && i_in_valid && i_start_req) ? '0 : r_fill;
    assign ev_need    = purge || (fill_base >= k);
    assign fill_m1    = fill_base - KW'(1);
    assign ev_age     = fill_m1[AW-1:0];
    assign fill_post  = fill_base - (ev_need ? KW'(1) : KW'(0));
    assign done       = acc && ((fill_post + KW'(1)) == k);

    assign ctrl.ins   = acc;
    assign ctrl.ev    = ev_need;
    assign ctrl.purge = purge;

    // Row ends
    assign val_a[N]      = '0;
    assign age_a[N]      = '0;
    assign flags_a[N]    = '0;
    assign post_val_a[0] = '0;
    assign post_age_a[0] = '0;
    assign post_gt_a[0]  = 1'b0;

    // Row of cells, one entry each, kept sorted ascending from cell 0
    for (genvar gi = 0; gi < N; gi++) begin : g_cell
        swm_cell #(
            .W   (W),
            .AW  (AW),
            .KW  (KW),
            .IDX (gi)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_sample      (i_sample),
            .i_ev_val      ($signed(ev_val)),
            .i_ev_age      (ev_age),
            .i_fill        (fill_base),
            .i_fill_post   (fill_post),
            .i_mid_lo      (mid_lo),
            .i_mid_hi      (mid_hi),
            .i_rt_val      (val_a[gi+1]),
            .i_rt_age      (age_a[gi+1]),
            .i_rt_flags    (flags_a[gi+1]),
            .i_lf_post_val (post_val_a[gi]),
            .i_lf_post_age (post_age_a[gi]),
            .i_lf_post_gt  (post_gt_a[gi]),
            .o_val         (val_a[gi]),
            .o_age         (age_a[gi]),
            .o_flags       (flags_a[gi]),
            .o_post_val    (post_val_a[gi+1]),
            .o_post_age    (post_age_a[gi+1]),
            .o_post_gt     (post_gt_a[gi+1]),
            .o_ev_tap      (ev_tap[gi]),
            .o_lo_tap      (lo_tap[gi]),
            .o_hi_tap      (hi_tap[gi])
        );
    end

    // Select trees: at most one cell drives each tap
    always_comb begin
        ev_val = '0;
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < N; i++) begin
            ev_val = ev_val | ev_tap[i];
            lo_val = lo_val | lo_tap[i];
            hi_val = hi_val | hi_tap[i];
        end
    end

    // Output register fed from the settled window
    assign load = r_pend && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_fill      = r_fill;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_med       = r_med;
        if (acc) begin
            n_fill = fill_post + KW'(1);
        end else if (purge) begin
            n_fill = fill_post;
        end
        if (load) begin
            n_med       = $signed({lo_val[W-1], lo_val}) + $signed({hi_val[W-1], hi_val});
            n_out_valid = 1'b1;
            n_pend      = 1'b0;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (done) begin
            n_pend = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws        <= WS_RESET;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ws <= i_cfg_wdata;
            end
            r_fill      <= n_fill;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_med <= n_med;
    end

    assign o_out_valid      = r_out_valid;
    assign o_median_doubled = r_med;

`ifndef SYNTHESIS
    // Fill never runs past the number of cells
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= 32'(WINDOW_MAX))
        else $error("fill count beyond cell count");

    // A result is only taken from a full window
    a_load_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (r_fill == k))
        else $error("median read from a window that is not full");

    // Each eviction-only cycle drops exactly one entry
    a_purge_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        purge |=> (r_fill == $past(r_fill) - KW'(1)))
        else $error("purge cycle did not remove one entry");

    // A start transaction leaves exactly the new sample in the window
    a_start_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_start_req) |=> (r_fill == KW'(1)))
        else $error("start did not restart the window");
`endif

endmodule

@@ hdl/swm_cell.sv @@
module swm_cell
    import swm_pkg::*;
#(
    parameter int W   = 32,
    parameter int AW  = 6,
    parameter int KW  = 7,
    parameter int IDX = 0
) (
    input  logic                 i_clk,
    input  t_cell_ctrl           i_ctrl,
    input  logic signed [W-1:0]  i_sample,
    input  logic signed [W-1:0]  i_ev_val,
    input  logic [AW-1:0]        i_ev_age,
    input  logic [KW-1:0]        i_fill,
    input  logic [KW-1:0]        i_fill_post,
    input  logic [KW-1:0]        i_mid_lo,
    input  logic [KW-1:0]        i_mid_hi,
    // right neighbor, current contents
    input  logic [W-1:0]         i_rt_val,
    input  logic [AW-1:0]        i_rt_age,
    input  t_cell_flags          i_rt_flags,
    // left neighbor, contents after eviction
    input  logic [W-1:0]         i_lf_post_val,
    input  logic [AW-1:0]        i_lf_post_age,
    input  logic                 i_lf_post_gt,
    output logic [W-1:0]         o_val,
    output logic [AW-1:0]        o_age,
    output t_cell_flags          o_flags,
    output logic [W-1:0]         o_post_val,
    output logic [AW-1:0]        o_post_age,
    output logic                 o_post_gt,
    output logic [W-1:0]         o_ev_tap,
    output logic [W-1:0]         o_lo_tap,
    output logic [W-1:0]         o_hi_tap
);

    logic [W-1:0]  r_val, n_val;
    logic [AW-1:0] r_age, n_age;
    logic          valid, post_valid, post_sel;
    logic [W-1:0]  post_val;
    logic [AW-1:0] post_base_age, post_age;

    // Occupancy follows from the fill count
    assign valid      = KW'(IDX) < i_fill;
    assign post_valid = KW'(IDX) < i_fill_post;

    // Equal values sit oldest first, so a younger equal entry lies past the evicted one
    assign o_flags.evb = i_ctrl.ev && valid &&
                         (($signed(r_val) > i_ev_val) ||
                          (($signed(r_val) == i_ev_val) && (r_age < i_ev_age)));
    assign o_flags.gt  = valid && ($signed(r_val) > i_sample);

    // Contents after the oldest entry is removed and the row closes up
    assign post_sel      = i_rt_flags.evb;
    assign post_val      = post_sel ? i_rt_val : r_val;
    assign post_base_age = post_sel ? i_rt_age : r_age;
    assign post_age      = post_base_age + (i_ctrl.ins ? AW'(1) : AW'(0));
    assign o_post_gt     = post_valid && (post_sel ? i_rt_flags.gt : o_flags.gt);
    assign o_post_val    = post_val;
    assign o_post_age    = post_age;

    // Sorted insert: larger entries move one cell right, the sample lands in the gap
    always_comb begin
        n_val = r_val;
        n_age = r_age;
        if (i_ctrl.ins) begin
            if (i_lf_post_gt) begin
                n_val = i_lf_post_val;
                n_age = i_lf_post_age;
            end else if (o_post_gt || !post_valid) begin
                n_val = i_sample;
                n_age = '0;
            end else begin
                n_val = post_val;
                n_age = post_age;
            end
        end else if (i_ctrl.purge) begin
            n_val = post_val;
            n_age = post_age;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_age <= n_age;
    end

    // Taps for the eviction broadcast and the median readout
    assign o_ev_tap = (valid && (r_age == i_ev_age)) ? r_val : '0;
    assign o_lo_tap = (KW'(IDX) == i_mid_lo) ? r_val : '0;
    assign o_hi_tap = (KW'(IDX) == i_mid_hi) ? r_val : '0;

    assign o_val = r_val;
    assign o_age = r_age;

endmodule
